/* rtl/core/bmb_pkg.sv */
// Shared types and fixed field widths of the best-four block matcher.
// No dependencies; the interfaces and the front, back and top core modules import it.
package bmb_pkg;

	localparam int unsigned PIX_W       = 10;
	localparam int unsigned REGION_W    = 4;
	localparam int unsigned BOUND_W     = 5;  // clamped bound, at most BLOCK_DIM
	localparam int unsigned COORD_W     = 3;
	localparam int unsigned COST_W      = 25;
	localparam int unsigned SQ_W        = 20;
	localparam int unsigned OUT_MATCHES = 4;

	localparam logic [COST_W-1:0] COST_MAX = '1;

	// item as it leaves the front: masked pixel and clamped region bounds
	typedef struct packed {
		logic [PIX_W-1:0]   pixel;
		logic               last;
		logic [BOUND_W-1:0] row_start;
		logic [BOUND_W-1:0] row_end;
		logic [BOUND_W-1:0] col_start;
		logic [BOUND_W-1:0] col_end;
	} bmb_item_t;

	typedef struct packed {
		logic busy;
		logic searching;
	} bmb_stat_t;

endpackage

/* rtl/core/bmb_if.sv */
// Handshake channels of the block matcher: pixel input and result output.
// Depends on bmb_pkg for field widths.
interface bmb_pix_if;
	import bmb_pkg::*;
	logic                valid;
	logic                ready;
	logic [PIX_W-1:0]    pixel;
	logic                window_last;
	logic [REGION_W-1:0] region_row_start;
	logic [REGION_W-1:0] region_row_end;
	logic [REGION_W-1:0] region_col_start;
	logic [REGION_W-1:0] region_col_end;

	modport source (output valid, pixel, window_last, region_row_start, region_row_end,
		region_col_start, region_col_end, input ready);
	modport sink (input valid, pixel, window_last, region_row_start, region_row_end,
		region_col_start, region_col_end, output ready);
endinterface

interface bmb_res_if;
	import bmb_pkg::*;
	logic               valid;
	logic               ready;
	logic [COORD_W-1:0] out_row;
	logic [COORD_W-1:0] out_col;
	logic [PIX_W-1:0]   best_match_0;
	logic [PIX_W-1:0]   best_match_1;
	logic [PIX_W-1:0]   best_match_2;
	logic [PIX_W-1:0]   best_match_3;
	logic [PIX_W-1:0]   reference_pixel;
	logic               result_last;

	modport source (output valid, out_row, out_col, best_match_0, best_match_1, best_match_2,
		best_match_3, reference_pixel, result_last, input ready);
	modport sink (input valid, out_row, out_col, best_match_0, best_match_1, best_match_2,
		best_match_3, reference_pixel, result_last, output ready);
endinterface

/* rtl/core/bmb_front.sv */
// Front end: takes pixel items, masks the pixel, clamps the region bounds
// and tags each item with its window store address. Depends on bmb_pkg, bmb_if.
module bmb_front #(
	parameter int unsigned BLOCK_DIM    = 8,
	parameter int unsigned SEARCH_RANGE = 8,
	parameter int unsigned PIXEL_BITS   = 10,
	parameter int unsigned AW           = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	bmb_pix_if.sink             pix_in,
	input  logic                q_ready,
	output logic                q_push,
	output logic [AW-1:0]       q_addr,
	output bmb_pkg::bmb_item_t  q_item
);
	import bmb_pkg::*;

	localparam int unsigned WIN   = BLOCK_DIM + SEARCH_RANGE;
	localparam int unsigned STORE = WIN * WIN;
	localparam logic [PIX_W-1:0] PIX_MASK = PIX_W'((1 << PIXEL_BITS) - 1);
	localparam logic [BOUND_W-1:0] DIM_B = BOUND_W'(BLOCK_DIM);

	logic [AW-1:0] fill_q;

	function automatic logic [BOUND_W-1:0] clamp_dim(input logic [REGION_W-1:0] v);
		logic [BOUND_W-1:0] w;
		w = BOUND_W'(v);
		return (w > DIM_B) ? DIM_B : w;
	endfunction

	assign pix_in.ready = q_ready;
	assign q_push       = pix_in.valid && q_ready;
	assign q_addr       = fill_q;

	always_comb begin
		q_item.pixel     = pix_in.pixel & PIX_MASK;
		q_item.last      = pix_in.window_last;
		q_item.row_start = clamp_dim(pix_in.region_row_start);
		q_item.row_end   = clamp_dim(pix_in.region_row_end);
		q_item.col_start = clamp_dim(pix_in.region_col_start);
		q_item.col_end   = clamp_dim(pix_in.region_col_end);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (q_push) begin
			if (pix_in.window_last || fill_q == AW'(STORE - 1)) begin
				fill_q <= '0;
			end else begin
				fill_q <= fill_q + 1'b1;
			end
		end
	end

endmodule

/* rtl/core/bmb_queue.sv */
// Two-entry queue between the front end and the search/emit engine.
// Depends on nothing but the clock and reset.
module bmb_queue #(
	parameter int unsigned WIDTH = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] din,
	output logic             ready,
	output logic             valid,
	output logic [WIDTH-1:0] dout,
	input  logic             pop
);
	logic [WIDTH-1:0] slot_q [2];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       cnt_q;

	assign ready = (cnt_q != 2'd2);
	assign valid = (cnt_q != 2'd0);
	assign dout  = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop)  rd_ptr_q <= ~rd_ptr_q;
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

/* rtl/core/bmb_back.sv */
// Back end: window store, SSD full search keeping the best matches, and
// region emission through an output register. Depends on bmb_pkg, bmb_if.
module bmb_back #(
	parameter int unsigned BLOCK_DIM    = 8,
	parameter int unsigned SEARCH_RANGE = 8,
	parameter int unsigned MATCH_COUNT  = 4,
	parameter int unsigned AW           = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                q_valid,
	input  logic [AW-1:0]       q_addr,
	input  bmb_pkg::bmb_item_t  q_item,
	output logic                q_pop,
	output bmb_pkg::bmb_stat_t  stat,
	bmb_res_if.source           res
);
	import bmb_pkg::*;

	localparam int unsigned WIN      = BLOCK_DIM + SEARCH_RANGE;
	localparam int unsigned STORE    = WIN * WIN;
	localparam int unsigned HALF     = SEARCH_RANGE / 2;
	localparam int unsigned REF_BASE = HALF * WIN + HALF;
	localparam int unsigned CW       = $clog2(SEARCH_RANGE + 1);
	localparam int unsigned TW       = $clog2(BLOCK_DIM);
	localparam int unsigned SW       = $clog2(OUT_MATCHES + 2);
	localparam int unsigned FW       = $clog2(MATCH_COUNT + 1);

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_SEARCH = 2'd1;
	localparam logic [1:0] ST_DRAIN  = 2'd2;
	localparam logic [1:0] ST_EMIT   = 2'd3;

	localparam logic [SW-1:0] STEP_REF  = SW'(OUT_MATCHES);
	localparam logic [SW-1:0] STEP_SEND = SW'(OUT_MATCHES + 1);

	logic [PIX_W-1:0] store_mem [STORE];
	logic [PIX_W-1:0] rd_a_q, rd_b_q;

	logic [1:0]         state_q;
	logic [CW-1:0]      cr_q, cc_q;
	logic [TW-1:0]      tr_q, tc_q;
	logic               vld_s1, vld_s2, vld_s3;
	logic               first_s1, first_s2, last_s1, last_s2;
	logic [AW-1:0]      base_s1, base_s2, base_s3;
	logic [SQ_W-1:0]    sq_s2;
	logic [COST_W-1:0]  acc_q, cost_s3;
	logic [COST_W-1:0]  best_cost_q [MATCH_COUNT];
	logic [AW-1:0]      best_off_q  [MATCH_COUNT];
	logic [FW-1:0]      filled_q;
	logic               empty_q;
	logic [BOUND_W-1:0] rs_q, re_q, cs_q, ce_q, er_q, ec_q;
	logic [SW-1:0]      es_q;
	logic [PIX_W-1:0]   fld_q [OUT_MATCHES];

	logic               out_valid_q, out_last_q;
	logic [COORD_W-1:0] out_row_q, out_col_q;
	logic [PIX_W-1:0]   out_match_q [OUT_MATCHES];
	logic [PIX_W-1:0]   out_ref_q;

	logic              issue, term_end, cand_last, load_out, res_last, rd_a_en;
	logic [AW-1:0]     cand_base, term_off, pos, sel_off, rd_a_addr;
	logic [CW-1:0]     nr, nc;
	logic signed [PIX_W:0]   diff_s1;
	logic signed [2*PIX_W+1:0] sq_full;
	logic [COST_W-1:0] acc_base, acc_next;
	logic [COST_W:0]   acc_sum;
	logic              hit  [MATCH_COUNT];
	logic              take [MATCH_COUNT];
	logic              region_empty;

	assign q_pop          = (state_q == ST_IDLE) && q_valid;
	assign stat.busy      = (state_q != ST_IDLE);
	assign stat.searching = (state_q == ST_SEARCH);

	assign issue     = (state_q == ST_SEARCH);
	assign cand_base = AW'(WIN) * AW'(cr_q) + AW'(cc_q);
	assign term_off  = AW'(WIN) * AW'(tr_q) + AW'(tc_q);
	assign term_end  = (tc_q == TW'(BLOCK_DIM - 1)) && (tr_q == TW'(BLOCK_DIM - 1));
	assign cand_last = (cr_q == CW'(SEARCH_RANGE)) && (cc_q == CW'(SEARCH_RANGE));
	assign pos       = AW'(WIN) * AW'(er_q) + AW'(ec_q);

	assign region_empty = (q_item.row_start >= q_item.row_end) ||
		(q_item.col_start >= q_item.col_end);

	// next candidate, column-major scan, centre skipped
	always_comb begin
		if (cr_q == CW'(SEARCH_RANGE)) begin
			nr = '0;
			nc = cc_q + 1'b1;
		end else begin
			nr = cr_q + 1'b1;
			nc = cc_q;
		end
		if (nr == CW'(HALF) && nc == CW'(HALF)) begin
			nr = nr + 1'b1;
		end
	end

	always_comb begin
		sel_off = '0;
		for (int j = 0; j < MATCH_COUNT; j++) begin
			if (SW'(j) == es_q) sel_off = best_off_q[j];
		end
	end

	always_comb begin
		rd_a_en   = 1'b0;
		rd_a_addr = AW'(REF_BASE) + term_off;
		if (issue) begin
			rd_a_en = 1'b1;
		end else if (state_q == ST_EMIT && es_q < STEP_REF) begin
			rd_a_en   = 1'b1;
			rd_a_addr = sel_off + pos;
		end else if (state_q == ST_EMIT && es_q == STEP_REF) begin
			rd_a_en   = 1'b1;
			rd_a_addr = AW'(REF_BASE) + pos;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) store_mem[q_addr] <= q_item.pixel;
		if (rd_a_en) rd_a_q <= store_mem[rd_a_addr];
		if (issue) rd_b_q <= store_mem[cand_base + term_off];
	end

	assign diff_s1 = $signed({1'b0, rd_a_q}) - $signed({1'b0, rd_b_q});
	assign sq_full = diff_s1 * diff_s1;

	// saturating accumulation: the sum never exceeds twice the cost range
	always_comb begin
		acc_base = first_s2 ? '0 : acc_q;
		acc_sum  = {1'b0, acc_base} + (COST_W + 1)'(sq_s2);
		acc_next = acc_sum[COST_W] ? COST_MAX : acc_sum[COST_W-1:0];
	end

	// insertion point: first slot still empty or strictly worse
	always_comb begin
		for (int j = 0; j < MATCH_COUNT; j++) begin
			hit[j] = (FW'(j) >= filled_q) || (cost_s3 < best_cost_q[j]);
		end
		take[0] = hit[0];
		for (int j = 1; j < MATCH_COUNT; j++) begin
			take[j] = take[j-1] || hit[j];
		end
	end

	assign res_last = (er_q + 1'b1 == re_q) && (ec_q + 1'b1 == ce_q);
	assign load_out = (state_q == ST_EMIT) && (es_q == STEP_SEND) &&
		(!out_valid_q || res.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cr_q        <= '0;
			cc_q        <= '0;
			tr_q        <= '0;
			tc_q        <= '0;
			vld_s1      <= 1'b0;
			vld_s2      <= 1'b0;
			vld_s3      <= 1'b0;
			first_s1    <= 1'b0;
			first_s2    <= 1'b0;
			last_s1     <= 1'b0;
			last_s2     <= 1'b0;
			filled_q    <= '0;
			empty_q     <= 1'b0;
			rs_q        <= '0;
			re_q        <= '0;
			cs_q        <= '0;
			ce_q        <= '0;
			er_q        <= '0;
			ec_q        <= '0;
			es_q        <= '0;
			out_valid_q <= 1'b0;
			for (int j = 0; j < MATCH_COUNT; j++) begin
				best_cost_q[j] <= COST_MAX;
				best_off_q[j]  <= '0;
			end
		end else begin
			vld_s1   <= issue;
			first_s1 <= issue && tr_q == '0 && tc_q == '0;
			last_s1  <= issue && term_end;
			vld_s2   <= vld_s1;
			first_s2 <= first_s1;
			last_s2  <= vld_s1 && last_s1;
			vld_s3   <= vld_s2 && last_s2;

			if (vld_s3 && take[MATCH_COUNT-1]) begin
				for (int j = 0; j < MATCH_COUNT; j++) begin
					if (take[j]) begin
						if (j > 0 && take[j > 0 ? j - 1 : 0]) begin
							best_cost_q[j] <= best_cost_q[j > 0 ? j - 1 : 0];
							best_off_q[j]  <= best_off_q[j > 0 ? j - 1 : 0];
						end else begin
							best_cost_q[j] <= cost_s3;
							best_off_q[j]  <= base_s3;
						end
					end
				end
				if (filled_q != FW'(MATCH_COUNT)) filled_q <= filled_q + 1'b1;
			end

			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (res.ready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (q_pop && q_item.last) begin
						rs_q     <= q_item.row_start;
						re_q     <= q_item.row_end;
						cs_q     <= q_item.col_start;
						ce_q     <= q_item.col_end;
						empty_q  <= region_empty;
						cr_q     <= '0;
						cc_q     <= '0;
						tr_q     <= '0;
						tc_q     <= '0;
						filled_q <= '0;
						for (int j = 0; j < MATCH_COUNT; j++) begin
							best_cost_q[j] <= COST_MAX;
							best_off_q[j]  <= '0;
						end
						state_q <= ST_SEARCH;
					end
				end
				ST_SEARCH: begin
					if (tc_q == TW'(BLOCK_DIM - 1)) begin
						tc_q <= '0;
						tr_q <= (tr_q == TW'(BLOCK_DIM - 1)) ? '0 : tr_q + 1'b1;
					end else begin
						tc_q <= tc_q + 1'b1;
					end
					if (term_end) begin
						cr_q <= nr;
						cc_q <= nc;
						if (cand_last) state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (!vld_s1 && !vld_s2 && !vld_s3) begin
						er_q    <= rs_q;
						ec_q    <= cs_q;
						es_q    <= '0;
						state_q <= empty_q ? ST_IDLE : ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (es_q != STEP_SEND) begin
						es_q <= es_q + 1'b1;
					end else if (load_out) begin
						es_q <= '0;
						if (ec_q + 1'b1 == ce_q) begin
							ec_q <= cs_q;
							er_q <= er_q + 1'b1;
						end else begin
							ec_q <= ec_q + 1'b1;
						end
						if (res_last) state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		base_s1 <= cand_base;
		base_s2 <= base_s1;
		sq_s2   <= sq_full[SQ_W-1:0];
		if (vld_s2) acc_q <= acc_next;
		if (vld_s2 && last_s2) begin
			cost_s3 <= acc_next;
			base_s3 <= base_s2;
		end
		if (state_q == ST_EMIT) begin
			for (int k = 0; k < OUT_MATCHES; k++) begin
				if (es_q == SW'(k + 1)) fld_q[k] <= (k < MATCH_COUNT) ? rd_a_q : '0;
			end
		end
		if (load_out) begin
			out_row_q  <= er_q[COORD_W-1:0];
			out_col_q  <= ec_q[COORD_W-1:0];
			out_ref_q  <= rd_a_q;
			out_last_q <= res_last;
			for (int k = 0; k < OUT_MATCHES; k++) begin
				out_match_q[k] <= fld_q[k];
			end
		end
	end

	assign res.valid           = out_valid_q;
	assign res.out_row         = out_row_q;
	assign res.out_col         = out_col_q;
	assign res.best_match_0    = out_match_q[0];
	assign res.best_match_1    = out_match_q[1];
	assign res.best_match_2    = out_match_q[2];
	assign res.best_match_3    = out_match_q[3];
	assign res.reference_pixel = out_ref_q;
	assign res.result_last     = out_last_q;

endmodule

/* rtl/core/block_match_best_four_core.sv */
// Channel   Dir  Modport  Moves
// pix_in    in   sink     one window pixel item, bounds sampled with the last
// res_out   out  source   one block pixel of the four matches and the reference
//
// Pixels enter the store at one item a cycle, while the back end is idle, through
// a two-entry queue. After the last pixel the search visits 80 candidates of 64
// terms each (one squared difference a cycle, set by the two read ports of the
// window store) and then drains its pipeline; each result then takes five
// store reads, one per match and one for the reference.
// Reset clears control state only; the store needs no clearing. A stalled
// result holds in the output register and pauses emission.
// Depends on bmb_pkg, bmb_if, bmb_front, bmb_queue, bmb_back.
module block_match_best_four_core #(
	parameter int unsigned BLOCK_DIM    = 8,
	parameter int unsigned SEARCH_RANGE = 8,
	parameter int unsigned MATCH_COUNT  = 4,
	parameter int unsigned PIXEL_BITS   = 10
) (
	input  logic      clk,
	input  logic      arst_n,
	bmb_pix_if.sink   pix_in,
	bmb_res_if.source res_out
);
	import bmb_pkg::*;

	localparam int unsigned WIN = BLOCK_DIM + SEARCH_RANGE;
	localparam int unsigned AW  = $clog2(WIN * WIN);
	localparam int unsigned QW  = AW + $bits(bmb_item_t);

	logic          f_push, q_ready, q_valid, q_pop;
	logic [AW-1:0] f_addr, b_addr;
	bmb_item_t     f_item, b_item;
	bmb_stat_t     bk_stat;
	logic [QW-1:0] q_dout;

	bmb_front #(
		.BLOCK_DIM(BLOCK_DIM), .SEARCH_RANGE(SEARCH_RANGE),
		.PIXEL_BITS(PIXEL_BITS), .AW(AW)
	) u_front (
		.clk(clk), .arst_n(arst_n), .pix_in(pix_in), .q_ready(q_ready),
		.q_push(f_push), .q_addr(f_addr), .q_item(f_item)
	);

	bmb_queue #(.WIDTH(QW)) u_queue (
		.clk(clk), .arst_n(arst_n), .push(f_push), .din({f_addr, f_item}),
		.ready(q_ready), .valid(q_valid), .dout(q_dout), .pop(q_pop)
	);

	assign {b_addr, b_item} = q_dout;

	bmb_back #(
		.BLOCK_DIM(BLOCK_DIM), .SEARCH_RANGE(SEARCH_RANGE),
		.MATCH_COUNT(MATCH_COUNT), .AW(AW)
	) u_back (
		.clk(clk), .arst_n(arst_n), .q_valid(q_valid), .q_addr(b_addr),
		.q_item(b_item), .q_pop(q_pop), .stat(bk_stat), .res(res_out)
	);

	a_pop_has_item: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid)
		else $error("queue popped while empty");

	a_busy_no_pop: assert property (@(posedge clk) disable iff (!arst_n)
		bk_stat.busy |-> !q_pop)
		else $error("item taken while search or emission under way");

	a_last_ends_window: assert property (@(posedge clk) disable iff (!arst_n)
		res_out.valid && res_out.ready && res_out.result_last |=> !res_out.valid)
		else $error("result follows the last result of a window");

	a_search_quiet_out: assert property (@(posedge clk) disable iff (!arst_n)
		bk_stat.searching && !res_out.valid |=> !res_out.valid)
		else $error("result appeared during the search");

endmodule
